FILE: hdl/spq_pkg.sv
// Shared types, widths and status codes for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int ACTION_W = 1;
    localparam int PRIO_W   = 4;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic                load;         // capture a result this cycle
        logic                insert;       // place the new entry
        logic                remove;       // pop the head entry
        logic [STATUS_W-1:0] status_code;  // status of this beat
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/spq_if.sv
// Handshake channel interfaces for request and response beats.
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if;
    logic                        valid;
    logic                        ready;
    logic [spq_pkg::ACTION_W-1:0] action;
    logic [spq_pkg::PRIO_W-1:0]   priority_req;
    logic [spq_pkg::ID_W-1:0]     order_id;

    modport source (output valid, output action, output priority_req, output order_id,
                    input ready);
    modport sink   (input valid, input action, input priority_req, input order_id,
                    output ready);
endinterface

interface spq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::PRIO_W-1:0]   out_priority;
    logic [spq_pkg::ID_W-1:0]     out_order_id;
    logic [spq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output out_priority, output out_order_id,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_priority, input out_order_id,
                    input occupancy, output ready);
endinterface

`default_nettype wire

FILE: hdl/spq_ctrl.sv
// Handshake controller: accepts request beats and holds the response slot.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                action,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire spq_pkg::dp_status_t dp_status,
    output spq_pkg::cmd_t            cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign in_ready  = (state_reg == S_IDLE) || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_HOLD);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (accept)
                    state_next = S_HOLD;
                else if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load   = accept;
        cmd.insert = accept && (action == spq_pkg::ACT_INSERT) && !dp_status.full;
        cmd.remove = accept && (action == spq_pkg::ACT_REMOVE) && !dp_status.empty;
        if (action == spq_pkg::ACT_INSERT)
            cmd.status_code = dp_status.full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
        else
            cmd.status_code = dp_status.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: hdl/spq_datapath.sv
// Sorted entry cells with compare-and-shift insert, head pop and result register.
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath #(
    parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spq_pkg::cmd_t                 cmd,
    input  wire logic [spq_pkg::PRIO_W-1:0]    priority_req,
    input  wire logic [spq_pkg::ID_W-1:0]      order_id,
    output spq_pkg::dp_status_t                dp_status,
    output logic [spq_pkg::STATUS_W-1:0]       status,
    output logic [spq_pkg::PRIO_W-1:0]         out_priority,
    output logic [spq_pkg::ID_W-1:0]           out_order_id,
    output logic [spq_pkg::OCC_W-1:0]          occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [spq_pkg::PRIO_W-1:0] prio_reg [QUEUE_DEPTH];
    logic [spq_pkg::PRIO_W-1:0] prio_next [QUEUE_DEPTH];
    logic [spq_pkg::ID_W-1:0]   id_reg [QUEUE_DEPTH];
    logic [spq_pkg::ID_W-1:0]   id_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]     occ_reg;
    logic [QUEUE_DEPTH-1:0]     occ_next;
    logic [QUEUE_DEPTH-1:0]     ge;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;

    logic [spq_pkg::STATUS_W-1:0] status_reg;
    logic [spq_pkg::PRIO_W-1:0]   rprio_reg;
    logic [spq_pkg::ID_W-1:0]     rid_reg;
    logic [spq_pkg::OCC_W-1:0]    occup_reg;

    assign dp_status.full  = occ_reg[QUEUE_DEPTH-1];
    assign dp_status.empty = !occ_reg[0];

    // Each cell keeps its entry if it outranks or ties the new one.
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            ge[i] = occ_reg[i] && (prio_reg[i] >= priority_req);
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            prio_next[i] = prio_reg[i];
            id_next[i]   = id_reg[i];
        end
        occ_next   = occ_reg;
        count_next = count_reg;
        if (cmd.insert)
        begin
            if (!ge[0])
            begin
                prio_next[0] = priority_req;
                id_next[0]   = order_id;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++)
            begin
                if (!ge[i])
                begin
                    if (ge[i-1])
                    begin
                        prio_next[i] = priority_req;
                        id_next[i]   = order_id;
                    end
                    else
                    begin
                        prio_next[i] = prio_reg[i-1];
                        id_next[i]   = id_reg[i-1];
                    end
                end
            end
            occ_next   = occ_reg | {occ_reg[QUEUE_DEPTH-2:0], 1'b1};
            count_next = count_reg + CW'(1);
        end
        else if (cmd.remove)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                prio_next[i] = prio_reg[i+1];
                id_next[i]   = id_reg[i+1];
            end
            occ_next   = {1'b0, occ_reg[QUEUE_DEPTH-1:1]};
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            prio_reg[i] <= prio_next[i];
            id_reg[i]   <= id_next[i];
        end
        if (cmd.load)
        begin
            status_reg <= cmd.status_code;
            rprio_reg  <= cmd.remove ? prio_reg[0] : '0;
            rid_reg    <= cmd.remove ? id_reg[0] : '0;
            occup_reg  <= spq_pkg::OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            occ_reg   <= occ_next;
            count_reg <= count_next;
        end
    end

    assign status       = status_reg;
    assign out_priority = rprio_reg;
    assign out_order_id = rid_reg;
    assign occupancy    = occup_reg;

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg[0] == (count_reg != '0))
        else $error("head occupancy disagrees with count");

    a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg[QUEUE_DEPTH-1] == (count_reg == CW'(QUEUE_DEPTH)))
        else $error("tail occupancy disagrees with count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the queue");

    a_remove_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |=> rprio_reg == $past(prio_reg[0]))
        else $error("removed priority is not the old head");

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: controller plus entry datapath.
//
//  channel | role | beat contents
//  --------+------+-------------------------------------------------------------
//  req     | sink | action, priority_req, order_id (insert or remove request)
//  rsp     | src  | status, out_priority, out_order_id, occupancy (one per req)
//
//  Each request beat is executed in the cycle it is accepted: the whole row of
//  entry cells compares against the new priority and shifts in one step, so the
//  response is valid on the next cycle.
//  A new request is taken while a response waits only in the cycle that
//  response is taken, so one beat per cycle is sustained when rsp is ready.
//  A stall on rsp holds the response register and blocks req.
//  Reset empties the queue at once; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    spq_pkg::cmd_t       cmd;
    spq_pkg::dp_status_t dp_status;

    // Handshake sequencing and per-beat decision (insert, remove, reject).
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .action    (req.action),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Sorted cells, occupancy and the response register.
    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .priority_req (req.priority_req),
        .order_id     (req.order_id),
        .dp_status    (dp_status),
        .status       (rsp.status),
        .out_priority (rsp.out_priority),
        .out_order_id (rsp.out_order_id),
        .occupancy    (rsp.occupancy)
    );

endmodule

`default_nettype wire
